FILE: design/pbo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_pkg: shared types and constants for the PolyBLEP oscillator
// Waveform codes, register indexes, fixed-point widths and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package pbo_pkg;

	localparam int PHASE_W  = 32;   // phase accumulator and increment width
	localparam int SAMPLE_W = 16;   // output sample width, Q1.15
	localparam int VAL_W    = 34;   // signed Q4.30 working value with headroom
	localparam int QUOT_W   = 30;   // PolyBLEP ratio in Q30, always below one
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W   = 5;

	localparam int FRAC_SHIFT = 30 - (SAMPLE_W - 1);

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SAW      = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	typedef enum logic {
		REG_PHASE_INC = 1'b0,
		REG_WAVE_SEL  = 1'b1
	} reg_idx_t;

	// gain-compensated 1.0 in Q30
	localparam logic [VAL_W-1:0] CORDIC_X0 = VAL_W'(34'h026DD3B6A);

	// divider handshake between sequencer and divider
	typedef struct packed {
		logic                start;
		logic [PHASE_W-1:0]  num;
		logic [PHASE_W-1:0]  den;
	} div_req_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0:  r = 32'h20000000;
				5'd1:  r = 32'h12E4051E;
				5'd2:  r = 32'h09FB385B;
				5'd3:  r = 32'h051111D4;
				5'd4:  r = 32'h028B0D43;
				5'd5:  r = 32'h0145D7E1;
				5'd6:  r = 32'h00A2F61E;
				5'd7:  r = 32'h00517C55;
				5'd8:  r = 32'h0028BE53;
				5'd9:  r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA;
				5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30;
				5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C;
				5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3;
				5'd23: r = 32'h00000051;
				5'd24: r = 32'h00000029;
				5'd25: r = 32'h00000014;
				5'd26: r = 32'h0000000A;
				5'd27: r = 32'h00000005;
				5'd28: r = 32'h00000003;
				5'd29: r = 32'h00000001;
				default: r = 32'h00000000;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: design/polyblep_waveform_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_waveform_oscillator: phase-accumulator oscillator with PolyBLEP
// Sine, saw, square and triangle from a 32-bit phase, Q1.15 output.
// ----------------------------------------------------------------------------
// One beat in gives one sample out, then the phase advances by phase_increment.
// Each beat is worked by a small sequencer over shared iterative units, and
// in_ready stays low until the sample is in the output register. Triangle
// goes straight to the output stage; sine runs 30 CORDIC iterations; saw and
// square use the bit-serial divider plus a registered multiply for each
// PolyBLEP correction. The next beat may be accepted while a sample waits on
// out_ready. Write configuration only while the block is idle.
module polyblep_waveform_oscillator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [pbo_pkg::PHASE_W-1:0]            cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   restart,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pbo_pkg::SAMPLE_W-1:0]    sample
);

	typedef enum logic [2:0] {
		S_IDLE, S_CORDIC, S_BSEL, S_DIV, S_MUL, S_ACC, S_FIN
	} state_t;

	localparam int VW = pbo_pkg::VAL_W;
	localparam int PW = pbo_pkg::PHASE_W;
	localparam int UW = pbo_pkg::QUOT_W + 1;
	localparam logic signed [VW-1:0] Q30_ONE = VW'(34'sh040000000);
	localparam logic [UW-1:0] U_ONE = UW'(31'h40000000);
	localparam logic [PW-1:0] HALF_TURN = 32'h80000000;

	state_t                    state_q;
	logic [PW-1:0]             phase_q;
	logic [PW-1:0]             inc_q;
	pbo_pkg::wave_t            wave_q;
	logic [PW-1:0]             t_q;
	logic                      pass_q;
	logic                      neg_q;
	logic [pbo_pkg::STEP_W-1:0] step_q;
	logic signed [VW-1:0]      acc_q;
	logic signed [VW-1:0]      x_q;
	logic signed [VW-1:0]      y_q;
	logic signed [VW-1:0]      z_q;
	logic [2*UW-1:0]           prod_q;
	logic                      out_valid_q;
	logic signed [pbo_pkg::SAMPLE_W-1:0] sample_q;

	logic [PW-1:0]             t_in;
	logic [PW-1:0]             tb;
	logic [PW:0]               tb_sum;
	logic                      near_start;
	logic                      near_end;
	logic                      sub_pass;
	pbo_pkg::div_req_t         div_req;
	logic                      div_done;
	logic [pbo_pkg::QUOT_W-1:0] div_quot;
	logic [UW-1:0]             u;
	logic signed [VW-1:0]      corr;
	logic signed [VW-1:0]      x_sh;
	logic signed [VW-1:0]      y_sh;
	logic signed [VW-1:0]      atan_v;
	logic signed [VW-1:0]      z_init;
	logic signed [VW-1:0]      tri_v;
	logic signed [VW-1:0]      rnd;
	logic signed [VW-pbo_pkg::FRAC_SHIFT-1:0] scaled;
	logic signed [pbo_pkg::SAMPLE_W-1:0]      sat;
	logic                      out_free;

	// phase seen by this beat
	assign t_in = restart ? '0 : phase_q;

	// fold into [-1/4, 1/4] turn for the CORDIC angle
	always_comb begin
		if (t_in[31] ^ t_in[30])
			z_init = VW'(34'sh080000000) - $signed({2'b00, t_in});
		else
			z_init = {{2{t_in[31]}}, t_in};
	end

	// naive triangle
	always_comb begin
		if (t_in[31] ^ t_in[30])
			tri_v = VW'(34'sh080000000) - $signed({2'b00, t_in});
		else
			tri_v = {{2{t_in[31]}}, t_in};
	end

	// PolyBLEP region test on the current pass
	assign tb         = pass_q ? (t_q + HALF_TURN) : t_q;
	assign tb_sum     = {1'b0, tb} + {1'b0, inc_q};
	assign near_start = (tb < inc_q);
	assign near_end   = tb_sum > {1'b1, {PW{1'b0}}};
	assign sub_pass   = (wave_q == pbo_pkg::WAVE_SAW) || pass_q;

	always_comb begin
		div_req.start = (state_q == S_BSEL) && (inc_q != '0) && (near_start || near_end);
		div_req.num   = near_start ? tb : (PW'(0) - tb);
		div_req.den   = inc_q;
	end

	pbo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign u    = U_ONE - {1'b0, div_quot};
	assign corr = neg_q ? -$signed({2'b00, prod_q[2*UW-1:30]})
	                    :  $signed({2'b00, prod_q[2*UW-1:30]});

	// CORDIC shared shift-add datapath
	assign x_sh   = x_q >>> step_q;
	assign y_sh   = y_q >>> step_q;
	assign atan_v = $signed({2'b00, pbo_pkg::atan_turn(step_q)});

	// round and saturate to Q1.15
	assign rnd    = acc_q + VW'(34'sd1 <<< (pbo_pkg::FRAC_SHIFT - 1));
	assign scaled = rnd[VW-1:pbo_pkg::FRAC_SHIFT];
	always_comb begin
		if (scaled > $signed((VW-pbo_pkg::FRAC_SHIFT)'((1 << (pbo_pkg::SAMPLE_W-1)) - 1)))
			sat = {1'b0, {(pbo_pkg::SAMPLE_W-1){1'b1}}};
		else if (scaled < -$signed((VW-pbo_pkg::FRAC_SHIFT)'(1 << (pbo_pkg::SAMPLE_W-1))))
			sat = {1'b1, {(pbo_pkg::SAMPLE_W-1){1'b0}}};
		else
			sat = scaled[pbo_pkg::SAMPLE_W-1:0];
	end

	assign out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q  <= '0;
			wave_q <= pbo_pkg::WAVE_SINE;
		end else if (cfg_we) begin
			unique case (pbo_pkg::reg_idx_t'(cfg_index))
				pbo_pkg::REG_PHASE_INC: inc_q  <= cfg_data;
				pbo_pkg::REG_WAVE_SEL:  wave_q <= pbo_pkg::wave_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// sequencer, phase and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= t_in + inc_q;
						pass_q  <= 1'b0;
						unique case (wave_q)
							pbo_pkg::WAVE_SINE:     state_q <= S_CORDIC;
							pbo_pkg::WAVE_TRIANGLE: state_q <= S_FIN;
							default:                state_q <= S_BSEL;
						endcase
					end
				end
				S_CORDIC: begin
					if (step_q == pbo_pkg::STEP_W'(pbo_pkg::CORDIC_STEPS - 1))
						state_q <= S_FIN;
				end
				S_BSEL: begin
					if (div_req.start)
						state_q <= S_DIV;
					else if (wave_q == pbo_pkg::WAVE_SQUARE && !pass_q)
						pass_q <= 1'b1;
					else
						state_q <= S_FIN;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (wave_q == pbo_pkg::WAVE_SQUARE && !pass_q) begin
						pass_q  <= 1'b1;
						state_q <= S_BSEL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q    <= t_in;
				step_q <= '0;
				x_q    <= pbo_pkg::CORDIC_X0;
				y_q    <= '0;
				z_q    <= z_init;
				unique case (wave_q)
					pbo_pkg::WAVE_SAW:
						acc_q <= $signed({3'b000, t_in[PW-1:1]}) - Q30_ONE;
					pbo_pkg::WAVE_SQUARE:
						acc_q <= t_in[PW-1] ? -Q30_ONE : Q30_ONE;
					pbo_pkg::WAVE_TRIANGLE:
						acc_q <= tri_v;
					default:
						acc_q <= '0;
				endcase
			end
			S_CORDIC: begin
				step_q <= step_q + 1'b1;
				if (!z_q[VW-1]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + atan_v;
				end
				if (step_q == pbo_pkg::STEP_W'(pbo_pkg::CORDIC_STEPS - 1))
					acc_q <= z_q[VW-1] ? (y_q - x_sh) : (y_q + x_sh);
			end
			S_BSEL: begin
				// near the start the correction is negative, but positive on a subtracting pass (saw, square's second pass)
				neg_q <= near_start ^ sub_pass;
			end
			S_MUL: prod_q <= u * u;
			S_ACC: acc_q  <= acc_q + corr;
			S_FIN: begin
				if (out_free)
					sample_q <= sat;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

FILE: design/pbo_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_div: iterative restoring divider
// Computes floor(num * 2^30 / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pbo_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pbo_pkg::div_req_t                req,
	output logic                             done,
	output logic [pbo_pkg::QUOT_W-1:0]       quot
);

	logic [pbo_pkg::PHASE_W-1:0]  rem_q;
	logic [pbo_pkg::PHASE_W-1:0]  den_q;
	logic [pbo_pkg::QUOT_W-1:0]   quot_q;
	logic [pbo_pkg::STEP_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [pbo_pkg::PHASE_W:0]    shifted;
	logic [pbo_pkg::PHASE_W:0]    diff;
	logic                         fits;

	// one trial subtract per cycle
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pbo_pkg::STEP_W'(pbo_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: remainder and quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[pbo_pkg::PHASE_W-1:0] : shifted[pbo_pkg::PHASE_W-1:0];
			quot_q <= {quot_q[pbo_pkg::QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: dv/tb_polyblep_waveform_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyblep_waveform_oscillator: self-checking bench for the oscillator
// Drives beats and restarts under random phase increments and waveforms, predicts
// every sample with a behavioral model of the phase accumulator, CORDIC sine,
// PolyBLEP saw and square and naive triangle, and checks each output beat.
// ----------------------------------------------------------------------------
module tb_polyblep_waveform_oscillator;

	localparam int CLK_PERIOD   = 20;
	localparam int DRAIN_CYCLES = 80;    // longer than the slowest square sample
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_BEATS = 1200;

	// arctangent of 2^-i in 2^-32 turn units
	localparam logic [31:0] ARCTAN_TURNS [pbo_pkg::CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};
	localparam longint Q30 = 64'sd1 << 30;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic                                 cfg_index;
	logic [pbo_pkg::PHASE_W-1:0]          cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic                                 restart;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [pbo_pkg::SAMPLE_W-1:0]  sample;

	// model state
	logic [31:0]                          osc_phase;
	logic [31:0]                          osc_step;
	pbo_pkg::wave_t                       osc_wave;
	logic signed [pbo_pkg::SAMPLE_W-1:0]  expected_samples [$];

	int  error_count;
	int  checked_count;
	int  wave_count [4];
	int  restart_count;
	int  idle_cycles;
	bit  steady;                 // no idling on either side
	int  out_stall_left;

	polyblep_waveform_oscillator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// PolyBLEP residual in Q30
	function automatic longint blep_residual(input logic [31:0] t, input logic [31:0] dt);
		logic [63:0] ratio;
		logic [63:0] rem;
		begin
			if (dt == 32'd0)
				return 0;
			if (t < dt) begin
				ratio = ({32'd0, t} << 30) / {32'd0, dt};
				rem   = 64'(Q30) - ratio;
				return -longint'((rem * rem) >> 30);
			end
			if ({32'd0, t} + {32'd0, dt} > (64'd1 << 32)) begin
				ratio = (((64'd1 << 32) - {32'd0, t}) << 30) / {32'd0, dt};
				if (ratio > 64'(Q30))
					ratio = 64'(Q30);
				rem = 64'(Q30) - ratio;
				return longint'((rem * rem) >> 30);
			end
			return 0;
		end
	endfunction

	// quarter-wave folded CORDIC rotation, Q30
	function automatic longint cordic_sine(input logic [31:0] t);
		longint angle;
		longint cx;
		longint cy;
		longint nx;
		begin
			cx = 64'sh26DD3B6A;
			cy = 0;
			if (t >= 32'h40000000 && t < 32'hC0000000)
				angle = (64'sd1 << 31) - longint'({32'd0, t});
			else if (t < 32'h40000000)
				angle = longint'({32'd0, t});
			else
				angle = longint'({32'd0, t}) - (64'sd1 << 32);
			for (int i = 0; i < pbo_pkg::CORDIC_STEPS; i++) begin
				if (angle >= 0) begin
					nx = cx - (cy >>> i);
					cy = cy + (cx >>> i);
					angle -= longint'({32'd0, ARCTAN_TURNS[i]});
				end else begin
					nx = cx + (cy >>> i);
					cy = cy - (cx >>> i);
					angle += longint'({32'd0, ARCTAN_TURNS[i]});
				end
				cx = nx;
			end
			return cy;
		end
	endfunction

	// one oscillator sample: optional restart, shape, round, saturate, advance
	function automatic logic signed [pbo_pkg::SAMPLE_W-1:0] next_sample(input logic clear);
		longint v;
		longint r;
		logic [31:0] t;
		begin
			if (clear)
				osc_phase = 32'd0;
			t = osc_phase;
			case (osc_wave)
				pbo_pkg::WAVE_SINE: v = cordic_sine(t);
				pbo_pkg::WAVE_SAW:
					v = longint'({32'd0, t >> 1}) - Q30 - blep_residual(t, osc_step);
				pbo_pkg::WAVE_SQUARE: begin
					v = (t < 32'h80000000) ? Q30 : -Q30;
					v += blep_residual(t, osc_step);
					v -= blep_residual(t + 32'h80000000, osc_step);
				end
				default: begin
					if (t < 32'h40000000)
						v = longint'({32'd0, t});
					else if (t < 32'hC0000000)
						v = (64'sd1 << 31) - longint'({32'd0, t});
					else
						v = longint'({32'd0, t}) - (64'sd1 << 32);
				end
			endcase
			r = (v + (64'sd1 << (pbo_pkg::FRAC_SHIFT - 1))) >>> pbo_pkg::FRAC_SHIFT;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			osc_phase = osc_phase + osc_step;
			return pbo_pkg::SAMPLE_W'(r);
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int random_gap();
		int pick;
		begin
			pick = $urandom_range(0, 99);
			if (steady || pick < 50)
				return 0;
			if (pick < 90)
				return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	// send one beat, with restart if clear is set, and log its expected sample
	task automatic send_beat(input logic clear);
		int gap;
		begin
			expected_samples.push_back(next_sample(clear));
			wave_count[osc_wave]++;
			if (clear)
				restart_count++;
			in_valid <= 1'b1;
			restart  <= clear;
			do @(posedge clk); while (!in_ready);
			gap = random_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				restart  <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every expected sample has arrived, then let the block settle
	task automatic wait_idle();
		begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (expected_samples.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_reg(input pbo_pkg::reg_idx_t idx,
			input logic [pbo_pkg::PHASE_W-1:0] value);
		begin
			wait_idle();
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= value;
			@(posedge clk);
			cfg_we    <= 1'b0;
			if (idx == pbo_pkg::REG_PHASE_INC)
				osc_step = value;
			else
				osc_wave = pbo_pkg::wave_t'(value[1:0]);
		end
	endtask

	task automatic set_osc(input pbo_pkg::wave_t w, input logic [31:0] step);
		begin
			write_reg(pbo_pkg::REG_WAVE_SEL, pbo_pkg::PHASE_W'(w));
			write_reg(pbo_pkg::REG_PHASE_INC, step);
		end
	endtask

	// reset values: sine at zero increment, then quarter-turn points of each shape
	task automatic test_quarter_points();
		begin
			send_beat(1'b0);
			send_beat(1'b1);
			for (int w = 0; w < 4; w++) begin
				set_osc(pbo_pkg::wave_t'(w), 32'h40000000);
				send_beat(1'b1);
				repeat (4) send_beat(1'b0);
			end
		end
	endtask

	// increment extremes: zero, smallest, one half, beyond one half, all ones
	task automatic test_increment_extremes();
		begin
			set_osc(pbo_pkg::WAVE_SQUARE, 32'h00000000);
			send_beat(1'b1);
			send_beat(1'b0);
			set_osc(pbo_pkg::WAVE_SAW, 32'h00000001);
			send_beat(1'b1);
			send_beat(1'b0);
			set_osc(pbo_pkg::WAVE_SQUARE, 32'h80000000);
			send_beat(1'b1);
			send_beat(1'b0);
			send_beat(1'b0);
			set_osc(pbo_pkg::WAVE_SAW, 32'hFFFFFFFF);
			send_beat(1'b1);
			send_beat(1'b0);
			send_beat(1'b0);
			set_osc(pbo_pkg::WAVE_SQUARE, 32'hC0000001);
			send_beat(1'b0);
			send_beat(1'b0);
		end
	endtask

	// random phases of random settings; runs with pick 3 pause midway until drained
	task automatic test_random_sweep();
		int sent;
		int run;
		int pick;
		logic [31:0] step;
		begin
			sent = 0;
			while (sent < RANDOM_BEATS) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0:       step = 32'h00000000;
					1:       step = 32'h80000000;
					2:       step = $urandom;
					3, 4:    step = $urandom_range(1, 32'h00FFFFFF);
					default: step = $urandom_range(32'h01000000, 32'h80000000);
				endcase
				set_osc(pbo_pkg::wave_t'($urandom_range(0, 3)), step);
				steady = ($urandom_range(0, 4) == 0);
				run = $urandom_range(20, 120);
				for (int i = 0; i < run; i++) begin
					send_beat($urandom_range(0, 19) == 0);
					if (i == run / 2 && pick == 3)
						wait_idle();
				end
				steady = 1'b0;
				sent += run;
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= pbo_pkg::REG_PHASE_INC;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		osc_phase = 32'd0;
		osc_step  = 32'd0;
		osc_wave  = pbo_pkg::WAVE_SINE;
		steady    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_quarter_points();
		test_increment_extremes();
		test_random_sweep();
		wait_idle();

		$display("Checked %0d samples (sine %0d, saw %0d, square %0d, triangle %0d)",
			checked_count, wave_count[0], wave_count[1], wave_count[2], wave_count[3]);
		$display("with %0d restarts over random increments and waveforms", restart_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls with steady stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready      <= 1'b0;
			out_stall_left <= 0;
		end else if (out_stall_left > 0) begin
			out_ready      <= 1'b0;
			out_stall_left <= out_stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				out_stall_left <= random_gap();
		end
	end

	// compare each output beat with the oldest expected sample
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample: expected none, actual %0d", $time, sample);
				error_count++;
			end else begin
				if (sample !== expected_samples[0]) begin
					$display("%0t: sample mismatch: expected %0d, actual %0d",
						$time, expected_samples[0], sample);
					error_count++;
				end
				void'(expected_samples.pop_front());
				checked_count++;
			end
		end
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		error_count   = 0;
		checked_count = 0;
		restart_count = 0;
		idle_cycles   = 0;
		foreach (wave_count[i])
			wave_count[i] = 0;
	end

endmodule
